// ===== hw/rtl/tfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tfcs_pkg
// Shared widths, defaults and the ranked-entry type of the top-five selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tfcs_pkg;

    localparam int VALUE_W         = 16;
    localparam int CLASS_W         = 10;
    localparam int RANK_W          = 3;
    localparam int MAX_CLASSES_DEF = 1024;
    localparam int TOP_COUNT_DEF   = 5;

    typedef struct packed {
        logic               filled;
        logic [CLASS_W-1:0] class_idx;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/top_five_class_selector_unit.sv =====
// ----------------------------------------------------------------------------
// top_five_class_selector_unit
// Streaming top-k selector: a chain of rank cells keeps the largest values.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while in_ready is high; the cell chain updates in the accept cycle.
// Latency: rank 0 of a run is shown the cycle after its last item is accepted,
// then one rank per cycle while out_ready is high, TOP_COUNT results in all.
// A last item stalls only while the previous run's results are still draining.
// Reset: rst_n clears the ranked list, item count, overflow flag, output valid and rank.
`default_nettype none

module top_five_class_selector_unit #(
    parameter int MAX_CLASSES = tfcs_pkg::MAX_CLASSES_DEF,
    parameter int TOP_COUNT   = tfcs_pkg::TOP_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [tfcs_pkg::VALUE_W-1:0]   probability,
    input  wire logic                           last_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tfcs_pkg::RANK_W-1:0]         rank,
    output logic [tfcs_pkg::CLASS_W-1:0]        class_index,
    output logic [tfcs_pkg::VALUE_W-1:0]        class_value,
    output logic                                found,
    output logic                                overflowed,
    output logic                                last_result
);

    localparam int ITEM_W = $clog2(MAX_CLASSES + 1);
    localparam int CW     = tfcs_pkg::CLASS_W;
    localparam logic [ITEM_W-1:0] MAX_ITEMS = ITEM_W'(MAX_CLASSES);

    logic [ITEM_W-1:0]  items_seen_reg;
    logic               ovf_reg;
    logic               accept;
    logic               full_hit;
    logic               insert;
    logic               end_run;
    logic               can_load;
    logic [CW-1:0]      new_class;

    logic               take_vec  [TOP_COUNT];
    tfcs_pkg::entry_t   cur_entry [TOP_COUNT];
    tfcs_pkg::entry_t   nxt_entry [TOP_COUNT];

    assign in_ready  = !last_item || can_load;
    assign accept    = in_valid && in_ready;
    assign full_hit  = (items_seen_reg == MAX_ITEMS);
    assign insert    = accept && !full_hit;
    assign end_run   = accept && last_item;
    assign new_class = CW'(items_seen_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            items_seen_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (end_run)
        begin
            items_seen_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (accept)
        begin
            if (full_hit)
            begin
                ovf_reg <= 1'b1;
            end
            else
            begin
                items_seen_reg <= items_seen_reg + 1'b1;
            end
        end
    end

    for (genvar i = 0; i < TOP_COUNT; i++)
    begin : g_cell
        logic             take_prev;
        tfcs_pkg::entry_t prev_entry;

        if (i == 0)
        begin : g_head
            assign take_prev  = 1'b0;
            assign prev_entry = '0;
        end
        else
        begin : g_link
            assign take_prev  = take_vec[i-1];
            assign prev_entry = cur_entry[i-1];
        end

        tfcs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .update     (accept),
            .clear      (last_item),
            .insert     (insert),
            .new_value  (probability),
            .new_class  (new_class),
            .take_prev  (take_prev),
            .prev_entry (prev_entry),
            .take       (take_vec[i]),
            .entry      (cur_entry[i]),
            .entry_next (nxt_entry[i])
        );
    end

    tfcs_out_buffer #(
        .TOP_COUNT (TOP_COUNT)
    ) u_out_buffer (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (end_run),
        .snap        (nxt_entry),
        .snap_ovf    (ovf_reg || full_hit),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .rank        (rank),
        .class_index (class_index),
        .class_value (class_value),
        .found       (found),
        .overflowed  (overflowed),
        .last_result (last_result),
        .can_load    (can_load)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/tfcs_cell.sv =====
// ----------------------------------------------------------------------------
// tfcs_cell
// One rank of the sorted list: compares the incoming value, keeps its entry,
// takes the new item or its upper neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcs_cell (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               update,
    input  wire logic                               clear,
    input  wire logic                               insert,
    input  wire logic [tfcs_pkg::VALUE_W-1:0]       new_value,
    input  wire logic [tfcs_pkg::CLASS_W-1:0]       new_class,
    input  wire logic                               take_prev,
    input  wire tfcs_pkg::entry_t                   prev_entry,
    output logic                                    take,
    output tfcs_pkg::entry_t                        entry,
    output tfcs_pkg::entry_t                        entry_next
);

    tfcs_pkg::entry_t entry_reg;

    // new item lands behind every filled entry with value >= new value
    assign take  = !entry_reg.filled || (new_value > entry_reg.value);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (insert)
        begin
            if (take_prev)
            begin
                entry_next = prev_entry;
            end
            else if (take)
            begin
                entry_next.filled    = 1'b1;
                entry_next.class_idx = new_class;
                entry_next.value     = new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (update)
        begin
            entry_reg <= clear ? '0 : entry_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tfcs_out_buffer.sv =====
// ----------------------------------------------------------------------------
// tfcs_out_buffer
// Holds a snapshot of the ranked list and shifts it out, one rank per request.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcs_out_buffer #(
    parameter int TOP_COUNT = tfcs_pkg::TOP_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire tfcs_pkg::entry_t               snap [TOP_COUNT],
    input  wire logic                           snap_ovf,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [tfcs_pkg::RANK_W-1:0]         rank,
    output logic [tfcs_pkg::CLASS_W-1:0]        class_index,
    output logic [tfcs_pkg::VALUE_W-1:0]        class_value,
    output logic                                found,
    output logic                                overflowed,
    output logic                                last_result,
    output logic                                can_load
);

    localparam int CNT_W = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
    localparam int RW    = tfcs_pkg::RANK_W;
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TOP_COUNT - 1);

    tfcs_pkg::entry_t   buf_reg [TOP_COUNT];
    logic [CNT_W-1:0]   cnt_reg;
    logic               valid_reg;
    logic               ovf_reg;
    logic               pop;
    logic               final_pop;

    assign pop       = valid_reg && out_ready;
    assign final_pop = pop && (cnt_reg == LAST_CNT);
    assign can_load  = !valid_reg || final_pop;

    assign out_valid   = valid_reg;
    assign rank        = RW'(cnt_reg);
    assign class_index = buf_reg[0].class_idx;
    assign class_value = buf_reg[0].value;
    assign found       = buf_reg[0].filled;
    assign overflowed  = ovf_reg;
    assign last_result = (cnt_reg == LAST_CNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (pop)
        begin
            if (final_pop)
            begin
                valid_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= snap;
            ovf_reg <= snap_ovf;
        end
        else if (pop)
        begin
            for (int i = 0; i < TOP_COUNT - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
            buf_reg[TOP_COUNT-1] <= '0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tfcs_checker.sv =====
// ----------------------------------------------------------------------------
// tfcs_checker
// Port-level checks on the result stream of the top-five selector.
// ----------------------------------------------------------------------------
`default_nettype none

module tfcs_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [tfcs_pkg::RANK_W-1:0]    rank,
    input  wire logic [tfcs_pkg::CLASS_W-1:0]   class_index,
    input  wire logic [tfcs_pkg::VALUE_W-1:0]   class_value,
    input  wire logic                           found,
    input  wire logic                           overflowed,
    input  wire logic                           last_result
);

    logic mid_run;

    assign mid_run = out_valid && out_ready && !last_result;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rank)
            && $stable(class_index) && $stable(class_value) && $stable(found))
        else $error("stalled result changed");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        mid_run |=> out_valid && (rank == $past(rank) + 1'b1))
        else $error("result run broken or rank not consecutive");

    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        mid_run && !found |=> !found)
        else $error("filled rank after empty rank");

    a_descending: assert property (@(posedge clk) disable iff (!rst_n)
        mid_run && found |=> !found || (class_value <= $past(class_value)))
        else $error("ranked values not descending");

    a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
        mid_run |=> overflowed == $past(overflowed))
        else $error("overflow flag changed within a run");

endmodule

bind top_five_class_selector_unit tfcs_checker u_tfcs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .rank        (rank),
    .class_index (class_index),
    .class_value (class_value),
    .found       (found),
    .overflowed  (overflowed),
    .last_result (last_result)
);

`default_nettype wire
